// ===== rtl/polynomial_add_sub_multiply_top_assert.svh =====
// Assertion macros for the polynomial add, subtract and multiply block.
// Needs clk and rst_n in the scope of each file that uses the macros.
`ifndef POLYNOMIAL_ADD_SUB_MULTIPLY_TOP_ASSERT_SVH
`define POLYNOMIAL_ADD_SUB_MULTIPLY_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define PASM_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("Implication check failed.");
`define PASM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("Next-cycle check failed.");
`else
`define PASM_ASSERT_IMP(lbl, ante, cons)
`define PASM_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/pasm_pkg.sv =====
// Shared constants and types for the polynomial add, subtract and multiply block.
// Used by pasm_coeff_store, polynomial_add_sub_multiply_top and the testbench; no dependencies.
package pasm_pkg;

    localparam int MAX_DEGREE  = 15;
    localparam int COEFF_W     = 16;
    localparam int STORE_DEPTH = MAX_DEGREE + 1;
    localparam int DEG_W       = $clog2(STORE_DEPTH);
    localparam int OUT_DEG_W   = DEG_W + 1;
    localparam int SUM_W       = COEFF_W + 1;
    localparam int MUL_W       = 2 * COEFF_W;
    localparam int PROD_W      = 36;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SUMRD,
        S_MAC,
        S_DRAIN
    } state_t;

    typedef struct packed {
        logic                      we;
        logic [DEG_W-1:0]          addr;
        logic signed [COEFF_W-1:0] data;
    } store_wr_t;

endpackage

// ===== rtl/polynomial_add_sub_multiply_top.sv =====
// Loads are accepted only in the idle state. The item marked last starts a job that emits
// one result per degree d from ta+tb down to 0, where ta and tb are the top degrees loaded.
// For each degree the block reads the sum operands, then issues the product terms one at a
// time, as each coefficient memory has a single read port feeding one multiply-accumulate
// unit; it then drains the pipeline and waits until the output is free.
// Depends on pasm_pkg, pasm_coeff_store and polynomial_add_sub_multiply_top_assert.svh.
`include "polynomial_add_sub_multiply_top_assert.svh"

module polynomial_add_sub_multiply_top
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 cmd,
    input  logic [pasm_pkg::DEG_W-1:0]           degree,
    input  logic signed [pasm_pkg::COEFF_W-1:0]  coeff,
    input  logic                                 last,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [pasm_pkg::OUT_DEG_W-1:0]       out_degree,
    output logic signed [pasm_pkg::SUM_W-1:0]    sum,
    output logic signed [pasm_pkg::SUM_W-1:0]    difference,
    output logic signed [pasm_pkg::PROD_W-1:0]   product,
    output logic                                 in_sum_range,
    output logic                                 final_res
);

    pasm_pkg::state_t state_reg, state_next;

    logic [pasm_pkg::DEG_W-1:0]     ta_reg, tb_reg, ta_upd, tb_upd;
    logic [pasm_pkg::OUT_DEG_W-1:0] d_reg;
    logic [pasm_pkg::DEG_W-1:0]     i_reg, hi_reg, lo_val, hi_val;
    logic [pasm_pkg::OUT_DEG_W-1:0] j_full;
    logic                           sum_cap_reg, p1_vld_reg, p2_vld_reg;

    logic signed [pasm_pkg::COEFF_W-1:0] a_rd, b_rd;
    logic signed [pasm_pkg::MUL_W-1:0]   mul_reg;
    logic signed [pasm_pkg::PROD_W-1:0]  acc_reg;
    logic signed [pasm_pkg::SUM_W-1:0]   sum_reg, diff_reg;

    logic                                out_valid_reg;
    logic [pasm_pkg::OUT_DEG_W-1:0]      out_degree_reg;
    logic signed [pasm_pkg::SUM_W-1:0]   out_sum_reg, out_diff_reg;
    logic signed [pasm_pkg::PROD_W-1:0]  out_prod_reg;
    logic                                out_rng_reg, out_final_reg;

    pasm_pkg::store_wr_t       wr_a, wr_b;
    logic [pasm_pkg::DEG_W-1:0] raddr_a, raddr_b;
    logic                       accept, out_free, pipe_empty, out_load, job_clear;
    logic                       mac_issue, in_rng;
    logic [pasm_pkg::DEG_W-1:0] sum_top;

    assign accept     = in_valid && in_ready;
    assign out_free   = !out_valid_reg || out_ready;
    assign pipe_empty = !p1_vld_reg && !p2_vld_reg;
    assign ta_upd     = (accept && !cmd && degree > ta_reg) ? degree : ta_reg;
    assign tb_upd     = (accept && cmd && degree > tb_reg) ? degree : tb_reg;
    assign sum_top    = (ta_reg > tb_reg) ? ta_reg : tb_reg;
    assign in_rng     = d_reg <= {1'b0, sum_top};
    assign j_full     = d_reg - {1'b0, i_reg};
    assign lo_val     = (d_reg > {1'b0, tb_reg}) ?
                        pasm_pkg::DEG_W'(d_reg - {1'b0, tb_reg}) : '0;
    assign hi_val     = (d_reg > {1'b0, ta_reg}) ? ta_reg : d_reg[pasm_pkg::DEG_W-1:0];

    pasm_coeff_store u_store_a
    (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (wr_a),
        .clear (job_clear),
        .raddr (raddr_a),
        .rdata (a_rd)
    );

    pasm_coeff_store u_store_b
    (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (wr_b),
        .clear (job_clear),
        .raddr (raddr_b),
        .rdata (b_rd)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pasm_pkg::S_IDLE:
            begin
                if (in_valid && last)
                begin
                    state_next = pasm_pkg::S_SUMRD;
                end
            end
            pasm_pkg::S_SUMRD:
            begin
                state_next = pasm_pkg::S_MAC;
            end
            pasm_pkg::S_MAC:
            begin
                if (i_reg == hi_reg)
                begin
                    state_next = pasm_pkg::S_DRAIN;
                end
            end
            pasm_pkg::S_DRAIN:
            begin
                if (pipe_empty && out_free)
                begin
                    state_next = (d_reg == '0) ? pasm_pkg::S_IDLE : pasm_pkg::S_SUMRD;
                end
            end
            default:
            begin
                state_next = pasm_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready  = 1'b0;
        mac_issue = 1'b0;
        out_load  = 1'b0;
        raddr_a   = i_reg;
        raddr_b   = j_full[pasm_pkg::DEG_W-1:0];
        unique case (state_reg)
            pasm_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
            end
            pasm_pkg::S_SUMRD:
            begin
                raddr_a = d_reg[pasm_pkg::DEG_W-1:0];
                raddr_b = d_reg[pasm_pkg::DEG_W-1:0];
            end
            pasm_pkg::S_MAC:
            begin
                mac_issue = 1'b1;
            end
            pasm_pkg::S_DRAIN:
            begin
                out_load = pipe_empty && out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
        job_clear  = out_load && (d_reg == '0);
        wr_a.we    = accept && !cmd;
        wr_a.addr  = degree;
        wr_a.data  = coeff;
        wr_b.we    = accept && cmd;
        wr_b.addr  = degree;
        wr_b.data  = coeff;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pasm_pkg::S_IDLE;
            ta_reg        <= '0;
            tb_reg        <= '0;
            d_reg         <= '0;
            i_reg         <= '0;
            hi_reg        <= '0;
            sum_cap_reg   <= 1'b0;
            p1_vld_reg    <= 1'b0;
            p2_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            sum_cap_reg <= (state_reg == pasm_pkg::S_SUMRD);
            p1_vld_reg  <= mac_issue;
            p2_vld_reg  <= p1_vld_reg;
            if (job_clear)
            begin
                ta_reg <= '0;
                tb_reg <= '0;
            end
            else
            begin
                ta_reg <= ta_upd;
                tb_reg <= tb_upd;
            end
            if (accept && last)
            begin
                d_reg <= {1'b0, ta_upd} + {1'b0, tb_upd};
            end
            else if (out_load && d_reg != '0)
            begin
                d_reg <= d_reg - 1'b1;
            end
            if (state_reg == pasm_pkg::S_SUMRD)
            begin
                i_reg  <= lo_val;
                hi_reg <= hi_val;
            end
            else if (mac_issue && i_reg != hi_reg)
            begin
                i_reg <= i_reg + 1'b1;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (p1_vld_reg)
        begin
            mul_reg <= a_rd * b_rd;
        end
        if (state_reg == pasm_pkg::S_SUMRD)
        begin
            acc_reg <= '0;
        end
        else if (p2_vld_reg)
        begin
            acc_reg <= acc_reg +
                       {{(pasm_pkg::PROD_W - pasm_pkg::MUL_W){mul_reg[pasm_pkg::MUL_W-1]}},
                        mul_reg};
        end
        if (sum_cap_reg)
        begin
            sum_reg  <= {a_rd[pasm_pkg::COEFF_W-1], a_rd} + {b_rd[pasm_pkg::COEFF_W-1], b_rd};
            diff_reg <= {a_rd[pasm_pkg::COEFF_W-1], a_rd} - {b_rd[pasm_pkg::COEFF_W-1], b_rd};
        end
        if (out_load)
        begin
            out_degree_reg <= d_reg;
            out_sum_reg    <= in_rng ? sum_reg : '0;
            out_diff_reg   <= in_rng ? diff_reg : '0;
            out_prod_reg   <= acc_reg;
            out_rng_reg    <= in_rng;
            out_final_reg  <= (d_reg == '0);
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_degree   = out_degree_reg;
    assign sum          = out_sum_reg;
    assign difference   = out_diff_reg;
    assign product      = out_prod_reg;
    assign in_sum_range = out_rng_reg;
    assign final_res    = out_final_reg;

    `PASM_ASSERT_IMP(a_final_at_zero, out_valid && final_res, out_degree == '0)
    `PASM_ASSERT_IMP(a_mac_bound, state_reg == pasm_pkg::S_MAC, i_reg <= hi_reg)
    `PASM_ASSERT_IMP(a_acc_in_job, p2_vld_reg,
        state_reg == pasm_pkg::S_MAC || state_reg == pasm_pkg::S_DRAIN)
    `PASM_ASSERT_NEXT(a_clear_tops, job_clear, ta_reg == '0 && tb_reg == '0)

endmodule

// ===== rtl/pasm_coeff_store.sv =====
// Coefficient store for one polynomial: synchronous memory with per-entry valid bits.
// Depends on pasm_pkg. Entries that are not valid read as zero.
module pasm_coeff_store
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  pasm_pkg::store_wr_t                wr,
    input  logic                               clear,
    input  logic [pasm_pkg::DEG_W-1:0]         raddr,
    output logic signed [pasm_pkg::COEFF_W-1:0] rdata
);

    logic signed [pasm_pkg::COEFF_W-1:0] mem [pasm_pkg::STORE_DEPTH];
    logic [pasm_pkg::STORE_DEPTH-1:0]    valid_reg;
    logic signed [pasm_pkg::COEFF_W-1:0] rd_data_reg;
    logic                                rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem[wr.addr] <= wr.data;
        end
        rd_data_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (clear)
            begin
                valid_reg <= '0;
            end
            else if (wr.we)
            begin
                valid_reg[wr.addr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[raddr];
        end
    end

    assign rdata = rd_valid_reg ? rd_data_reg : '0;

endmodule

// ===== dv/polynomial_add_sub_multiply_top_tb.sv =====
// Self-checking testbench for polynomial_add_sub_multiply_top: loads coefficient transactions and
// checks each result row against a built-in sum, difference and convolution predictor.
// Depends on pasm_pkg and the polynomial_add_sub_multiply_top RTL.
module polynomial_add_sub_multiply_top_tb;

    typedef struct packed {
        logic [pasm_pkg::OUT_DEG_W-1:0] deg;
        logic [pasm_pkg::SUM_W-1:0]     sum_v;
        logic [pasm_pkg::SUM_W-1:0]     diff_v;
        logic [pasm_pkg::PROD_W-1:0]    prod_v;
        logic                           in_rng;
        logic                           fin;
    } poly_row_t;

    logic                                clk;
    logic                                rst_n;
    logic                                in_valid;
    logic                                in_ready;
    logic                                cmd;
    logic [pasm_pkg::DEG_W-1:0]          degree;
    logic signed [pasm_pkg::COEFF_W-1:0] coeff;
    logic                                last;
    logic                                out_valid;
    logic                                out_ready;
    logic [pasm_pkg::OUT_DEG_W-1:0]      out_degree;
    logic signed [pasm_pkg::SUM_W-1:0]   sum;
    logic signed [pasm_pkg::SUM_W-1:0]   difference;
    logic signed [pasm_pkg::PROD_W-1:0]  product;
    logic                                in_sum_range;
    logic                                final_res;

    logic signed [pasm_pkg::COEFF_W-1:0] first_poly [0:pasm_pkg::STORE_DEPTH-1];
    logic signed [pasm_pkg::COEFF_W-1:0] second_poly [0:pasm_pkg::STORE_DEPTH-1];
    int                                  first_top;
    int                                  second_top;
    poly_row_t                           pending_rows [$];

    int send_idle_pct;
    int recv_idle_pct;
    int items_sent;
    int error_count;

    polynomial_add_sub_multiply_top i_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .cmd          (cmd),
        .degree       (degree),
        .coeff        (coeff),
        .last         (last),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_degree   (out_degree),
        .sum          (sum),
        .difference   (difference),
        .product      (product),
        .in_sum_range (in_sum_range),
        .final_res    (final_res)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #6 clk = ~clk;
        end
    end

    initial
    begin
        #(12 * 1000000);
        $display("polynomial_add_sub_multiply_top verification failed");
        $finish;
    end

    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        error_count++;
    endtask

    // Stores one coefficient and, when it is marked last, queues every result row of the job.
    task automatic store_and_convolve(input logic sel, input logic [pasm_pkg::DEG_W-1:0] d,
                                      input logic signed [pasm_pkg::COEFF_W-1:0] v,
                                      input logic l);
        longint    conv [0:2*pasm_pkg::MAX_DEGREE];
        poly_row_t row;
        int        a;
        int        b;
        int        s_val;
        int        d_val;
        int        i;
        int        j;
        int        k;
        int        sum_top;
        if (sel == 1'b0)
        begin
            first_poly[d] = v;
            if (d > first_top)
                first_top = d;
        end
        else
        begin
            second_poly[d] = v;
            if (d > second_top)
                second_top = d;
        end
        if (l)
        begin
            for (k = 0; k <= 2 * pasm_pkg::MAX_DEGREE; k++)
                conv[k] = 0;
            for (i = 0; i <= first_top; i++)
                for (j = 0; j <= second_top; j++)
                    conv[i + j] += longint'(first_poly[i]) * longint'(second_poly[j]);
            sum_top = (first_top > second_top) ? first_top : second_top;
            for (k = first_top + second_top; k >= 0; k--)
            begin
                row.deg = k[pasm_pkg::OUT_DEG_W-1:0];
                if (k <= sum_top)
                begin
                    a          = first_poly[k];
                    b          = second_poly[k];
                    s_val      = a + b;
                    d_val      = a - b;
                    row.sum_v  = s_val[pasm_pkg::SUM_W-1:0];
                    row.diff_v = d_val[pasm_pkg::SUM_W-1:0];
                    row.in_rng = 1'b1;
                end
                else
                begin
                    row.sum_v  = '0;
                    row.diff_v = '0;
                    row.in_rng = 1'b0;
                end
                row.prod_v = conv[k][pasm_pkg::PROD_W-1:0];
                row.fin    = (k == 0);
                pending_rows = {pending_rows, row};
            end
            for (k = 0; k < pasm_pkg::STORE_DEPTH; k++)
            begin
                first_poly[k]  = '0;
                second_poly[k] = '0;
            end
            first_top  = 0;
            second_top = 0;
        end
    endtask

    always @(posedge clk)
    begin : check_rows
        poly_row_t exp_row;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_rows.size() == 0)
                report_mismatch($sformatf("unexpected result at degree %0d", out_degree));
            else
            begin
                exp_row = pending_rows.pop_front();
                if (out_degree !== exp_row.deg)
                    report_mismatch($sformatf("out_degree %0d, expected %0d",
                                              out_degree, exp_row.deg));
                if (sum !== exp_row.sum_v)
                    report_mismatch($sformatf("degree %0d sum %0d, expected %0d", exp_row.deg,
                                              sum, $signed(exp_row.sum_v)));
                if (difference !== exp_row.diff_v)
                    report_mismatch($sformatf("degree %0d difference %0d, expected %0d",
                                              exp_row.deg, difference,
                                              $signed(exp_row.diff_v)));
                if (product !== exp_row.prod_v)
                    report_mismatch($sformatf("degree %0d product %0d, expected %0d",
                                              exp_row.deg, product, $signed(exp_row.prod_v)));
                if (in_sum_range !== exp_row.in_rng)
                    report_mismatch($sformatf("degree %0d in_sum_range %b, expected %b",
                                              exp_row.deg, in_sum_range, exp_row.in_rng));
                if (final_res !== exp_row.fin)
                    report_mismatch($sformatf("degree %0d final_res %b, expected %b",
                                              exp_row.deg, final_res, exp_row.fin));
            end
        end
    end

    // Called and returns at a falling edge; valid stays high into the next call.
    task automatic send_coeff(input logic sel, input logic [pasm_pkg::DEG_W-1:0] d,
                              input logic signed [pasm_pkg::COEFF_W-1:0] v, input logic l);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        cmd      <= sel;
        degree   <= d;
        coeff    <= v;
        last     <= l;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        store_and_convolve(sel, d, v, l);
        items_sent++;
        @(negedge clk);
    endtask

    function automatic logic signed [pasm_pkg::COEFF_W-1:0] random_coeff();
        int          pick;
        int          short_val;
        logic [31:0] raw;
        pick      = $urandom_range(7);
        short_val = int'($urandom_range(4)) - 2;
        raw       = $urandom;
        case (pick)
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return short_val[pasm_pkg::COEFF_W-1:0];
            default: return raw[pasm_pkg::COEFF_W-1:0];
        endcase
    endfunction

    function automatic int random_top();
        if ($urandom_range(7) == 0)
            return $urandom_range(pasm_pkg::MAX_DEGREE);
        return $urandom_range(4);
    endfunction

    task automatic test_extreme_values();
        send_coeff(1'b0, 4'd15, 16'sh8000, 1'b0);
        send_coeff(1'b0, 4'd0, 16'sh7FFF, 1'b0);
        send_coeff(1'b1, 4'd15, 16'sh8000, 1'b0);
        send_coeff(1'b1, 4'd0, 16'sh8000, 1'b1);
        send_coeff(1'b0, 4'd15, 16'sh7FFF, 1'b0);
        send_coeff(1'b1, 4'd15, 16'sh7FFF, 1'b1);
    endtask

    task automatic test_unloaded_polynomial();
        send_coeff(1'b1, 4'd3, 16'sd1234, 1'b0);
        send_coeff(1'b1, 4'd0, -16'sd1, 1'b1);
        send_coeff(1'b0, 4'd0, 16'sd0, 1'b1);
        send_coeff(1'b0, 4'd9, -16'sd77, 1'b1);
    endtask

    task automatic test_overwrite();
        send_coeff(1'b0, 4'd2, 16'sd5, 1'b0);
        send_coeff(1'b1, 4'd1, 16'sd3, 1'b0);
        send_coeff(1'b0, 4'd2, -16'sd7, 1'b0);
        send_coeff(1'b1, 4'd1, 16'sd300, 1'b1);
    endtask

    task automatic test_leading_zero();
        send_coeff(1'b0, 4'd6, 16'sd0, 1'b0);
        send_coeff(1'b0, 4'd1, 16'sd9, 1'b0);
        send_coeff(1'b1, 4'd4, 16'sd0, 1'b0);
        send_coeff(1'b1, 4'd2, -16'sd11, 1'b1);
    endtask

    // Mostly dense polynomials in shuffled order, some with repeated loads; the rest are
    // short runs of arbitrary transactions.
    task automatic send_random_job();
        logic [pasm_pkg::DEG_W:0]            slots [$];
        logic [pasm_pkg::DEG_W:0]            tmp;
        logic signed [pasm_pkg::COEFF_W-1:0] v;
        int                                  ta;
        int                                  tb;
        int                                  k;
        int                                  idx;
        int                                  n;
        int                                  sel_r;
        int                                  deg_r;
        bit                                  fill;
        if ($urandom_range(9) == 0)
        begin
            n = $urandom_range(6, 1);
            for (k = 0; k < n; k++)
            begin
                sel_r = $urandom_range(1);
                deg_r = $urandom_range(pasm_pkg::MAX_DEGREE);
                send_coeff(sel_r[0], deg_r[pasm_pkg::DEG_W-1:0], random_coeff(),
                           (k == n - 1) || ($urandom_range(15) == 0));
            end
        end
        else
        begin
            fill = ($urandom_range(15) == 0);
            ta   = fill ? pasm_pkg::MAX_DEGREE : random_top();
            tb   = fill ? pasm_pkg::MAX_DEGREE : random_top();
            v    = ($urandom_range(1) == 0) ? 16'sh8000 : 16'sh7FFF;
            for (k = 0; k <= ta; k++)
                slots = {slots, {1'b0, k[pasm_pkg::DEG_W-1:0]}};
            for (k = 0; k <= tb; k++)
                slots = {slots, {1'b1, k[pasm_pkg::DEG_W-1:0]}};
            if ($urandom_range(3) == 0)
            begin
                tmp   = slots[$urandom_range(slots.size() - 1)];
                slots = {slots, tmp};
            end
            for (k = slots.size() - 1; k > 0; k--)
            begin
                idx        = $urandom_range(k);
                tmp        = slots[k];
                slots[k]   = slots[idx];
                slots[idx] = tmp;
            end
            for (k = 0; k < slots.size(); k++)
                send_coeff(slots[k][pasm_pkg::DEG_W], slots[k][pasm_pkg::DEG_W-1:0],
                           fill ? v : random_coeff(), k == slots.size() - 1);
        end
    endtask

    task automatic test_random_jobs(input int target);
        int start;
        start = items_sent;
        while (items_sent - start < target)
            send_random_job();
    endtask

    initial
    begin
        int k;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        cmd           = 1'b0;
        degree        = '0;
        coeff         = '0;
        last          = 1'b0;
        send_idle_pct = 31;
        recv_idle_pct = 47;
        items_sent    = 0;
        error_count   = 0;
        first_top     = 0;
        second_top    = 0;
        for (k = 0; k < pasm_pkg::STORE_DEPTH; k++)
        begin
            first_poly[k]  = '0;
            second_poly[k] = '0;
        end
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_extreme_values();
        test_unloaded_polynomial();
        test_overwrite();
        test_leading_zero();
        test_random_jobs(100);

        send_idle_pct = 47;
        recv_idle_pct = 31;
        test_random_jobs(115);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_jobs(115);

        in_valid <= 1'b0;
        while (pending_rows.size() != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
        if (error_count == 0)
            $display("polynomial_add_sub_multiply_top verification clean");
        else
            $display("polynomial_add_sub_multiply_top verification failed");
        $finish;
    end

endmodule
